// ===== sv/nfba_pkg.sv =====
// shared constants, codes and control types for the next-fit bitmap block allocator
`default_nettype none
package nfba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int NUM_W      = 11;
  localparam int INODE_W    = 10;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WORDS      = MAX_BLOCKS / WORD_W;
  localparam int WADDR_W    = $clog2(WORDS);
  localparam int NW_W       = $clog2(WORDS + 1);
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int STAT_W     = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_OCCUPIED = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic REG_INODE = 1'b0;
  localparam logic REG_DATA  = 1'b1;

  typedef struct packed {
    logic              capture;
    logic              start;
    logic              rd;
    logic              step;
    logic              commit;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic area_empty;
    logic range_err;
    logic found;
    logic last_word;
    logic occupied;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/nfba_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none
module nfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nfba_ctrl.sv =====
// controller state machine: sequences capture, word scan, commit and result beat
`default_nettype none
module nfba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire nfba_pkg::dp_stat_t stat,
  output      nfba_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_alloc && stat.area_empty) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = nfba_pkg::ST_FULL;
          state_next     = S_DONE;
        end else if (!stat.is_alloc && stat.range_err) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = nfba_pkg::ST_RANGE;
          state_next     = S_DONE;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_alloc) begin
          if (stat.found) begin
            cmd.commit     = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = nfba_pkg::ST_OK;
            state_next     = S_DONE;
          end else if (stat.last_word) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = nfba_pkg::ST_FULL;
            state_next     = S_DONE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_RD;
          end
        end else if (stat.occupied) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = nfba_pkg::ST_OCCUPIED;
          state_next     = S_DONE;
        end else begin
          cmd.commit     = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = nfba_pkg::ST_OK;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/nfba_dp.sv =====
// datapath: config registers, bitmap ram, search pointer, count and result register
`default_nettype none
module nfba_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [nfba_pkg::NUM_W-1:0]           cfg_data,
  input  wire logic [nfba_pkg::IN_DATA_W-1:0]       s_tdata,
  input  wire logic                                 s_tuser,
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  output      logic [nfba_pkg::OUT_DATA_W-1:0]      m_tdata,
  output      logic [nfba_pkg::STAT_W-1:0]          m_tuser,
  input  wire nfba_pkg::ctrl_cmd_t                  cmd,
  output      nfba_pkg::dp_stat_t                   stat
);

  localparam int NUM_W   = nfba_pkg::NUM_W;
  localparam int IDX_W   = nfba_pkg::IDX_W;
  localparam int WORD_W  = nfba_pkg::WORD_W;
  localparam int BIT_W   = nfba_pkg::BIT_W;
  localparam int WADDR_W = nfba_pkg::WADDR_W;
  localparam int NW_W    = nfba_pkg::NW_W;
  localparam int WORDS   = nfba_pkg::WORDS;

  logic [nfba_pkg::INODE_W-1:0] inode_area;
  logic [NUM_W-1:0]             data_area;
  logic                         cmd_r;
  logic [NUM_W-1:0]             req_r;
  logic [IDX_W-1:0]             ptr;
  logic [NUM_W-1:0]             used_count;
  logic [WADDR_W-1:0]           w;
  logic [NW_W-1:0]              k;
  logic [WORDS-1:0]             word_valid;
  logic [nfba_pkg::STAT_W-1:0]  res_status;
  logic [NUM_W-1:0]             res_granted;

  logic [NUM_W-1:0]   d;
  logic [NUM_W:0]     dsum;
  logic [NW_W-1:0]    nwords;
  logic [NW_W-1:0]    d_hi;
  logic [BIT_W-1:0]   d_lo;
  logic [IDX_W-1:0]   p_eff;
  logic [BIT_W-1:0]   p_lo;
  logic               under;
  logic [NUM_W-1:0]   diff;
  logic [IDX_W-1:0]   mark_idx;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  cur_word;
  logic [WORD_W-1:0]  area_mask;
  logic [WORD_W-1:0]  pass_mask;
  logic [WORD_W-1:0]  free_vec;
  logic [BIT_W-1:0]   enc;
  logic [BIT_W-1:0]   bit_pos;
  logic [NW_W-1:0]    w_inc;
  logic [WADDR_W-1:0] w_next;
  logic [IDX_W-1:0]   found_idx;
  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;

  assign d      = (data_area > NUM_W'(nfba_pkg::MAX_BLOCKS))
                  ? NUM_W'(nfba_pkg::MAX_BLOCKS) : data_area;
  assign dsum   = {1'b0, d} + (NUM_W + 1)'(WORD_W - 1);
  assign nwords = dsum[BIT_W +: NW_W];
  assign d_hi   = d[NUM_W-1:BIT_W];
  assign d_lo   = d[BIT_W-1:0];
  assign p_eff  = ({1'b0, ptr} >= d) ? '0 : ptr;
  assign p_lo   = p_eff[BIT_W-1:0];

  assign under    = req_r < NUM_W'(inode_area);
  assign diff     = req_r - NUM_W'(inode_area);
  assign mark_idx = diff[IDX_W-1:0];

  assign cur_word = word_valid[w] ? rd_data : '0;

  always_comb begin
    if ({1'b0, w} < d_hi) begin
      area_mask = '1;
    end else if ({1'b0, w} == d_hi) begin
      area_mask = ~({WORD_W{1'b1}} << d_lo);
    end else begin
      area_mask = '0;
    end
    if (k == '0) begin
      pass_mask = {WORD_W{1'b1}} << p_lo;
    end else if (k == nwords) begin
      pass_mask = ~({WORD_W{1'b1}} << p_lo);
    end else begin
      pass_mask = '1;
    end
  end

  assign free_vec = ~cur_word & area_mask & pass_mask;

  // lowest free bit
  always_comb begin
    enc = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        enc = BIT_W'(b);
      end
    end
  end

  assign found_idx = {w, enc};
  assign w_inc     = {1'b0, w} + NW_W'(1);
  assign w_next    = (w_inc == nwords) ? '0 : w_inc[WADDR_W-1:0];
  assign bit_pos   = cmd_r ? mark_idx[BIT_W-1:0] : enc;
  assign ram_we    = cmd.commit;
  assign ram_wdata = cur_word | (WORD_W'(1) << bit_pos);

  assign stat.is_alloc   = (cmd_r == nfba_pkg::CMD_ALLOC);
  assign stat.area_empty = (d == '0);
  assign stat.range_err  = under || (diff >= d);
  assign stat.found      = |free_vec;
  assign stat.last_word  = (k == nwords);
  assign stat.occupied   = cur_word[mark_idx[BIT_W-1:0]];
  assign stat.out_free   = !m_tvalid || m_tready;

  nfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (w),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_area <= '0;
      data_area  <= NUM_W'(nfba_pkg::MAX_BLOCKS);
      ptr        <= '0;
      used_count <= '0;
      word_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nfba_pkg::REG_INODE) begin
          inode_area <= cfg_data[nfba_pkg::INODE_W-1:0];
        end else begin
          data_area <= cfg_data;
        end
      end
      if (cmd.commit) begin
        word_valid[w] <= 1'b1;
        used_count    <= used_count + NUM_W'(1);
        if (cmd_r == nfba_pkg::CMD_ALLOC) begin
          ptr <= found_idx;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= s_tuser;
      req_r <= s_tdata[NUM_W-1:0];
    end
    if (cmd.start) begin
      w <= (cmd_r == nfba_pkg::CMD_ALLOC) ? p_eff[IDX_W-1:BIT_W] : mark_idx[IDX_W-1:BIT_W];
      k <= '0;
    end else if (cmd.step) begin
      w <= w_next;
      k <= k + NW_W'(1);
    end
    if (cmd.set_res) begin
      res_status  <= cmd.res_status;
      res_granted <= (cmd.commit && cmd_r == nfba_pkg::CMD_ALLOC)
                     ? NUM_W'(inode_area) + NUM_W'(found_idx) : '0;
    end
    if (cmd.out_load) begin
      m_tdata <= {(nfba_pkg::OUT_DATA_W - 2 * NUM_W)'(0), used_count, res_granted};
      m_tuser <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= NUM_W'(nfba_pkg::MAX_BLOCKS))
    else $error("in-use count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(used_count))
    else $error("in-use count moved without a commit");

  a_grant_in_area: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd_r == nfba_pkg::CMD_ALLOC |-> ({1'b0, found_idx} < d))
    else $error("allocated block outside data area");

  a_word_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> word_valid[$past(w)])
    else $error("written bitmap word not marked valid");

endmodule
`default_nettype wire

// ===== sv/next_fit_bitmap_block_allocator.sv =====
// top level of the next-fit bitmap block allocator
// One command is handled at a time. A mark passes through the check, ram read
// and evaluate states before its result is offered, and a mark out of range or
// an allocate on an empty area goes from the check state straight to the result.
// An allocate reads the bitmap one 32-bit word at a time, each word through a
// ram read state and an evaluate state, starting at the search pointer's word;
// when the area is full it reads ceil(D/32)+1 words, the start word twice.
// A result waits in the done state until the output register is free.
// The next command can be taken in the cycle after the result is offered, while
// that result may still wait on the output register. The bitmap is cleared at reset
// through per-word valid flags, so no clearing pass is needed; configuration
// writes leave map, pointer and count unchanged and should only happen while
// no command is in flight.
`default_nettype none
module next_fit_bitmap_block_allocator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [nfba_pkg::NUM_W-1:0]           cfg_data,
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  input  wire logic [nfba_pkg::IN_DATA_W-1:0]       s_tdata,   // request_block
  input  wire logic                                 s_tuser,   // command
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  output      logic [nfba_pkg::OUT_DATA_W-1:0]      m_tdata,   // granted_block, blocks_used
  output      logic [nfba_pkg::STAT_W-1:0]          m_tuser    // status
);

  nfba_pkg::ctrl_cmd_t cmd;
  nfba_pkg::dp_stat_t  stat;

  nfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
